// ----- sv/multi_slot_reminder_alarm_unit_assert.svh -----
// assertion macros for the reminder alarm unit
// used by the top level only, needs a clock named clk and a reset named rst
`ifndef MULTI_SLOT_REMINDER_ALARM_UNIT_ASSERT_SVH
`define MULTI_SLOT_REMINDER_ALARM_UNIT_ASSERT_SVH

`ifndef SYNTH
`define MSRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSRA_ASSERT(lbl, prop, msg)
`define MSRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/msra_pkg.sv -----
// shared types, codes and cadence constants of the reminder alarm unit
// no dependencies
`default_nettype none

package msra_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_CLEAR   = 3'd1;
  localparam logic [2:0] OP_CHECK   = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_DISMISS = 3'd4;

  localparam logic [1:0] KIND_OFF  = 2'd0;
  localparam logic [1:0] KIND_HOUR = 2'd2;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_DAY  = 2'd1;
  localparam logic [1:0] LVL_HOUR = 2'd2;
  localparam logic [1:0] LVL_NOW  = 2'd3;

  // rows: day, hour, now
  localparam logic [15:0] CAD_ON      [3] = '{16'd100, 16'd200, 16'd500};
  localparam logic [15:0] CAD_CYCLE   [3] = '{16'd2100, 16'd700, 16'd700};
  localparam logic [15:0] CAD_TIMEOUT [3] = '{16'd6000, 16'd20000, 16'd60000};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ARM,
    ST_DONE
  } msra_state_t;

  function automatic logic [1:0] cad_row(input logic [1:0] lvl);
    logic [1:0] r;
    r = 2'd0;
    if (lvl == LVL_HOUR) r = 2'd1;
    if (lvl == LVL_NOW) r = 2'd2;
    return r;
  endfunction

  function automatic logic [15:0] cad_on(input logic [1:0] lvl);
    return CAD_ON[cad_row(lvl)];
  endfunction

  function automatic logic [15:0] cad_cycle(input logic [1:0] lvl);
    return CAD_CYCLE[cad_row(lvl)];
  endfunction

  function automatic logic [15:0] cad_timeout(input logic [1:0] lvl);
    return CAD_TIMEOUT[cad_row(lvl)];
  endfunction

endpackage

`default_nettype wire

// ----- sv/multi_slot_reminder_alarm_unit.sv -----
// reminder alarm unit: slot table and fired flags in memories, scan sequencer,
// beep cadence. depends on msra_pkg and multi_slot_reminder_alarm_unit_assert.svh
//
// channel   dir  fields (low bit up)
// s_*       in   tuser: operation; tdata: slot, slot_kind, tomorrow, event_hour,
//                event_minute, now_hour, now_minute
// m_*       out  tdata: buzzer_on, reminder_active, reminder_level, reminder_slot,
//                just_armed
// cfg_*     in   active_slots, written whenever cfg_we is high
//
// results: load, clear, tick, dismiss, unused codes and a check while armed or
// with nothing to scan go from idle straight to done; a scanning check passes
// through scan and arm, one slot per cycle through the slot table read port.
// reset is immediate: fired flags carry one valid bit per slot, the slot table
// needs no clearing. a request is taken while a result waits in the output
// register and then holds in its last step until m_tready frees the register.
`default_nettype none

module multi_slot_reminder_alarm_unit #(
  parameter int SLOTS = msra_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [2:0]  s_tuser,   // operation
  input  wire logic [31:0] s_tdata,   // slot, slot_kind, tomorrow, event_hour,
                                      // event_minute, now_hour, now_minute
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // buzzer_on, reminder_active,
                                      // reminder_level, reminder_slot, just_armed
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  // input fields
  logic [2:0] in_op;
  logic [3:0] in_slot;
  logic [1:0] in_kind;
  logic       in_tmr;
  logic [4:0] in_eh;
  logic [5:0] in_em;
  logic [4:0] in_nh;
  logic [5:0] in_nm;

  assign in_op   = s_tuser;
  assign in_slot = s_tdata[3:0];
  assign in_kind = s_tdata[5:4];
  assign in_tmr  = s_tdata[6];
  assign in_eh   = s_tdata[11:7];
  assign in_em   = s_tdata[17:12];
  assign in_nh   = s_tdata[22:18];
  assign in_nm   = s_tdata[28:23];

  // memories
  logic [13:0] table_mem [SLOTS];
  logic [2:0]  fired_mem [SLOTS];
  logic [13:0] table_q;
  logic [2:0]  fired_q;
  logic        fired_ok_q;
  logic [SLOTS-1:0] fired_ok;

  // control and status
  msra_pkg::msra_state_t state, state_next;
  logic [4:0]    active_slots;
  logic [LW-1:0] limit, limit_in, idx;
  logic          rd_vld;
  logic [4:0]    now_h;
  logic [5:0]    now_m;
  logic [1:0]    best_level;
  logic [IW-1:0] best_idx, rd_idx;
  logic [2:0]    best_fired;
  logic          armed;
  logic [1:0]    armed_level;
  logic [IW-1:0] armed_slot;
  logic [15:0]   elapsed;
  logic [11:0]   phase;
  logic          just_armed;

  // combinational controls
  logic          accept, scan_issue, arm_go, out_load, load_we, fired_we;
  logic [IW-1:0] load_addr;
  logic [2:0]    fired_wdata;
  logic [1:0]    cand_level;
  logic [2:0]    cand_fired;
  logic          cand_hit;
  logic [15:0]   elapsed_inc;
  logic [11:0]   phase_inc;
  logic          timeout_hit, phase_wrap, buzzer;

  // the scan limit, active_slots clipped to the table depth
  assign limit_in = (LW'(active_slots) > LW'(SLOTS)) ? LW'(SLOTS) : LW'(active_slots);
  assign load_addr = IW'(in_slot);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      msra_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (in_op == msra_pkg::OP_CHECK && !armed && limit_in != '0) begin
            state_next = msra_pkg::ST_SCAN;
          end else begin
            state_next = msra_pkg::ST_DONE;
          end
        end
      end
      msra_pkg::ST_SCAN: begin
        if (!scan_issue && !rd_vld) state_next = msra_pkg::ST_ARM;
      end
      msra_pkg::ST_ARM: state_next = msra_pkg::ST_DONE;
      msra_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = msra_pkg::ST_IDLE;
      end
      default: state_next = msra_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = (state == msra_pkg::ST_IDLE);
    accept     = s_tready && s_tvalid;
    scan_issue = (state == msra_pkg::ST_SCAN) && (idx < limit);
    arm_go     = (state == msra_pkg::ST_ARM) && (best_level != msra_pkg::LVL_NONE);
    out_load   = (state == msra_pkg::ST_DONE) && (!m_tvalid || m_tready);
    load_we    = accept && (in_op == msra_pkg::OP_LOAD) && (32'(in_slot) < SLOTS);
    fired_we   = arm_go;
    fired_wdata = best_fired | (3'd1 << (best_level - 2'd1));
  end

  // candidate from the slot read last cycle
  always_comb begin
    logic [1:0] kind;
    logic       tmr;
    kind = table_q[13:12];
    tmr  = table_q[11];
    if (tmr) cand_level = msra_pkg::LVL_DAY;
    else if (kind == msra_pkg::KIND_HOUR) cand_level = msra_pkg::LVL_HOUR;
    else cand_level = msra_pkg::LVL_NOW;
    cand_fired = fired_ok_q ? fired_q : 3'd0;
    cand_hit = rd_vld && (kind != msra_pkg::KIND_OFF)
             && !cand_fired[2'(cand_level - 2'd1)]
             && (table_q[10:6] == now_h) && (table_q[5:0] == now_m)
             && (cand_level > best_level);
  end

  // cadence
  always_comb begin
    elapsed_inc = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
    timeout_hit = elapsed_inc >= msra_pkg::cad_timeout(armed_level);
    phase_inc   = phase + 12'd1;
    phase_wrap  = {4'd0, phase_inc} >= msra_pkg::cad_cycle(armed_level);
    buzzer      = armed && ({4'd0, phase} < msra_pkg::cad_on(armed_level));
  end

  // memories
  always_ff @(posedge clk) begin
    if (load_we) table_mem[load_addr] <= {in_kind, in_tmr, in_eh, in_em};
    if (scan_issue) begin
      table_q    <= table_mem[idx[IW-1:0]];
      fired_q    <= fired_mem[idx[IW-1:0]];
      fired_ok_q <= fired_ok[idx[IW-1:0]];
    end
    if (fired_we) fired_mem[best_idx] <= fired_wdata;
  end

  // sequencer and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= msra_pkg::ST_IDLE;
      active_slots <= 5'd0;
      fired_ok     <= '0;
      rd_vld       <= 1'b0;
      armed        <= 1'b0;
      armed_level  <= msra_pkg::LVL_NONE;
      armed_slot   <= '0;
      elapsed      <= 16'd0;
      phase        <= 12'd0;
      just_armed   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) active_slots <= cfg_wdata;

      if (accept) begin
        now_h      <= in_nh;
        now_m      <= in_nm;
        idx        <= '0;
        limit      <= limit_in;
        best_level <= msra_pkg::LVL_NONE;
        best_idx   <= '0;
        best_fired <= 3'd0;
        just_armed <= 1'b0;
        unique case (in_op)
          msra_pkg::OP_CLEAR: fired_ok <= '0;
          msra_pkg::OP_TICK: begin
            if (armed) begin
              if (timeout_hit) begin
                armed       <= 1'b0;
                armed_level <= msra_pkg::LVL_NONE;
                armed_slot  <= '0;
                elapsed     <= 16'd0;
                phase       <= 12'd0;
              end else begin
                elapsed <= elapsed_inc;
                phase   <= phase_wrap ? 12'd0 : phase_inc;
              end
            end
          end
          msra_pkg::OP_DISMISS: begin
            armed       <= 1'b0;
            armed_level <= msra_pkg::LVL_NONE;
            armed_slot  <= '0;
            elapsed     <= 16'd0;
            phase       <= 12'd0;
          end
          // load is handled by the memory block, check by the scan,
          // unused codes only report status
          default: ;
        endcase
      end

      if (scan_issue) begin
        idx    <= idx + LW'(1);
        rd_idx <= idx[IW-1:0];
      end
      rd_vld <= scan_issue;

      // strict greater keeps the lowest slot on equal levels
      if (cand_hit) begin
        best_level <= cand_level;
        best_idx   <= rd_idx;
        best_fired <= cand_fired;
      end

      if (arm_go) begin
        armed              <= 1'b1;
        armed_level        <= best_level;
        armed_slot         <= best_idx;
        elapsed            <= 16'd0;
        phase              <= 12'd0;
        just_armed         <= 1'b1;
        fired_ok[best_idx] <= 1'b1;
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, just_armed, 4'(armed_slot), armed_level, armed, buzzer};
    end
  end

  `include "multi_slot_reminder_alarm_unit_assert.svh"

  `MSRA_ASSERT(a_armed_has_level, armed |-> (armed_level != msra_pkg::LVL_NONE), "armed with no level")
  `MSRA_ASSERT(a_fresh_is_active, (m_tvalid && m_tdata[8]) |-> (m_tdata[1] && m_tdata[3:2] != 2'd0), "just armed result without active reminder")
  `MSRA_ASSERT(a_accept_leaves_idle, (s_tvalid && s_tready) |=> (state != msra_pkg::ST_IDLE), "request taken but sequencer stayed idle")
  `MSRA_ASSERT_ALWAYS(a_scan_only_unarmed, (!rst && state == msra_pkg::ST_SCAN) |-> !armed, "slot scan running while armed")

endmodule

`default_nettype wire
